### hw/rtl/fbpa_pkg.sv
// fbpa_pkg: shared types and codes for the fixed block pool allocator
// holds beat payload structs, action and register codes, control/status structs
// no dependencies
`timescale 1ns / 1ps

package fbpa_pkg;

  // free map word geometry
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int BYTE_MSB = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int BLEN_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ADDR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_LEN   = 2'd3;

  // action codes
  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_ACQUIRE = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_BM_WR   = 3'd3;
  localparam logic [2:0] ACT_BM_RD   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
  } fbpa_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] block_address;
    logic [7:0]  bitmap_byte;
  } fbpa_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic lim_load;
    logic ptr_clr;
    logic ptr_inc;
    logic clr_wr;
    logic fill_wr;
    logic scan_rd;
    logic hit_wr;
    logic rmw_rd;
    logic rmw_wr;
    logic res_ld;
  } fbpa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [2:0] act;
    logic       div_done;
    logic       ptr_last;
    logic       ptr_over;
    logic       hit;
    logic       miss_end;
    logic       chk_ok;
  } fbpa_stat_t;

endpackage

### hw/rtl/fbpa_div.sv
// fbpa_div: two-lane divider by a fixed block size using reciprocal multiplication
// gives quotient and remainder of both lanes in three steps; done pulses once when ready
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_div #(
  parameter int DIVISOR = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0][31:0] num,
  output logic [1:0][31:0] quo,
  output logic [1:0][$clog2(DIVISOR)-1:0] rem,
  output logic             done
);
  import fbpa_pkg::*;

  localparam int W     = 32;
  localparam int RMW   = $clog2(DIVISOR);
  localparam int SHIFT = W + RMW;
  localparam int CNT_W = 2;

  // ceil(2^SHIFT / DIVISOR) is exact for every 32-bit dividend and fits in 33 bits
  localparam logic [63:0] MAGIC  = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [15:0] MAG_LO = MAGIC[15:0];
  localparam logic [16:0] MAG_HI = MAGIC[32:16];
  localparam logic [W-1:0] DIV_W = W'(DIVISOR);

  localparam logic [CNT_W-1:0] ST_MUL = 2'd3;
  localparam logic [CNT_W-1:0] ST_QUO = 2'd2;
  localparam logic [CNT_W-1:0] ST_REM = 2'd1;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [1:0][W-1:0]   n_r;
  logic [1:0][47:0]    plo_r, plo_nxt;
  logic [1:0][48:0]    phi_r, phi_nxt;
  logic [1:0][64:0]    psum;
  logic [1:0][W-1:0]   q_r, q_nxt;
  logic [1:0][RMW-1:0] rem_r, rem_nxt;

  // partial products, quotient from the summed product, remainder by back-multiply
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      plo_nxt[l] = 48'(n_r[l]) * 48'(MAG_LO);
      phi_nxt[l] = 49'(n_r[l]) * 49'(MAG_HI);
      psum[l]    = 65'(plo_r[l]) + (65'(phi_r[l]) << 16);
      q_nxt[l]   = W'(psum[l] >> SHIFT);
      rem_nxt[l] = RMW'(n_r[l] - W'(q_r[l] * DIV_W));
    end
  end

  // step counter and done pulse
  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = ST_MUL;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == ST_REM) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // operand capture and per-step result registers
  always_ff @(posedge clk) begin
    if (start) n_r <= num;
    if (!start && cnt_r == ST_MUL) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (!start && cnt_r == ST_QUO) q_r <= q_nxt;
    if (!start && cnt_r == ST_REM) rem_r <= rem_nxt;
  end

  assign quo  = q_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

### hw/rtl/fbpa_datapath.sv
// fbpa_datapath: config registers, free map memory, divider and result registers
// acts on command strobes from fbpa_ctrl and reports status back
// depends on fbpa_pkg and fbpa_div
`timescale 1ns / 1ps

module fbpa_datapath #(
  parameter int NUM_BLOCKS = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fbpa_pkg::fbpa_in_t                  in_data,
  input  fbpa_pkg::fbpa_cmd_t                 cmd,
  output fbpa_pkg::fbpa_stat_t                st,
  output fbpa_pkg::fbpa_out_t                 out_data
);
  import fbpa_pkg::*;

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W     = $clog2(NUM_WORDS + 1);
  localparam int BIDX_W    = WA_W + BIT_W;
  localparam int IDX_W     = $clog2(NUM_BLOCKS + 1);
  localparam int RMW       = $clog2(BLOCK_SIZE);

  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(NUM_WORDS - 1);
  localparam logic [PTR_W-1:0]  OVER_PTR  = PTR_W'(NUM_WORDS);
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NUM_WORDS - 1);
  localparam logic [31:0]       NB_32     = 32'(NUM_BLOCKS);
  localparam logic [31:0]       BS_32     = 32'(BLOCK_SIZE);
  localparam logic [31:0]       NW_32     = 32'(NUM_WORDS);
  localparam logic [WORD_W-1:0] ONES      = '1;

  // configuration registers
  logic [31:0]       base_r, start_r, end_r;
  logic [BLEN_W-1:0] blen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      start_r <= '0;
      end_r   <= '0;
      blen_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHARED_BASE: base_r  <= cfg_data;
        CFG_START_ADDR:  start_r <= cfg_data;
        CFG_END_ADDR:    end_r   <= cfg_data;
        CFG_BITMAP_LEN:  blen_r  <= cfg_data[BLEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // input beat holding register
  fbpa_in_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // word pointer for clearing, filling and scanning
  logic [PTR_W-1:0] ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + PTR_W'(1);
    end
  end

  // divider lanes: init takes start/end offsets, free takes address offsets
  logic [1:0][31:0]     div_num, div_quo;
  logic [1:0][RMW-1:0]  div_rem;
  logic                 div_done;

  always_comb begin
    if (item_r.action == ACT_INIT) begin
      div_num[0] = start_r - base_r;
      div_num[1] = end_r - base_r;
    end else begin
      div_num[0] = item_r.address - base_r;
      div_num[1] = item_r.address - start_r;
    end
  end

  fbpa_div #(
    .DIVISOR (BLOCK_SIZE)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  // free range limits and free checks from the divider
  logic [31:0]       ceil0, ceil1, lo32, hi32, a_off, span;
  logic [IDX_W-1:0]  lo_nxt, hi_nxt, lo_r, hi_r;
  logic              chk_nxt, chk_ok_r;
  logic [BIDX_W-1:0] fidx_r;

  always_comb begin
    ceil0   = div_quo[0] + 32'(div_rem[0] != '0);
    ceil1   = div_quo[1] + 32'(div_rem[1] != '0);
    lo32    = (start_r <= base_r) ? 32'd0 : ceil0;
    hi32    = (end_r <= base_r) ? 32'd0 : ceil1;
    lo_nxt  = (lo32 > NB_32) ? IDX_W'(NUM_BLOCKS) : IDX_W'(lo32);
    hi_nxt  = (hi32 > NB_32) ? IDX_W'(NUM_BLOCKS) : IDX_W'(hi32);
    a_off   = item_r.address - start_r;
    span    = end_r - start_r;
    chk_nxt = (a_off < span) && (div_rem[1] == '0) && (item_r.address >= base_r) &&
              (div_rem[0] == '0) && (div_quo[0] < NB_32);
  end

  always_ff @(posedge clk) begin
    if (cmd.lim_load) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      chk_ok_r <= chk_nxt;
      fidx_r   <= div_quo[0][BIDX_W-1:0];
    end
  end

  // init fill word: blocks with lo <= index < hi are free
  logic [31:0]       wbase, lo_w, hi_w, lo_off, hi_off;
  logic [WORD_W-1:0] ge_mask, lt_mask, fill_word;

  always_comb begin
    wbase  = 32'(ptr_r) << BIT_W;
    lo_w   = 32'(lo_r);
    hi_w   = 32'(hi_r);
    lo_off = lo_w - wbase;
    hi_off = hi_w - wbase;
    if (lo_w <= wbase)                  ge_mask = ONES;
    else if (lo_w >= wbase + 32'(WORD_W)) ge_mask = '0;
    else                                ge_mask = ONES << lo_off[BIT_W-1:0];
    if (hi_w <= wbase)                  lt_mask = '0;
    else if (hi_w >= wbase + 32'(WORD_W)) lt_mask = ONES;
    else                                lt_mask = ~(ONES << hi_off[BIT_W-1:0]);
    fill_word = ge_mask & lt_mask;
  end

  // free map memory with registered read
  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rdata_r, mem_wdata;
  logic [WA_W-1:0]   mem_raddr, mem_waddr, rmw_addr;
  logic              mem_we, mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // scan read tracking
  logic            rd_valid_r;
  logic [WA_W-1:0] rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_valid_r <= 1'b0;
    else        rd_valid_r <= cmd.scan_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) rd_addr_r <= ptr_r[WA_W-1:0];
  end

  // lowest free block of the word just read
  logic [WORD_W-1:0] low_bit;
  logic [BIT_W-1:0]  low_pos;

  always_comb begin
    low_bit = rdata_r & (~rdata_r + WORD_W'(1));
    low_pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (low_bit[j]) low_pos = low_pos | BIT_W'(j);
    end
  end

  // acquired block index and hit flag
  logic [BIDX_W-1:0] found_idx_r;
  logic              acq_hit_r;
  logic [31:0]       acq_addr;

  always_ff @(posedge clk) begin
    if (cmd.hit_wr) found_idx_r <= {rd_addr_r, low_pos};
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          acq_hit_r <= 1'b0;
    else if (cmd.load)   acq_hit_r <= 1'b0;
    else if (cmd.hit_wr) acq_hit_r <= 1'b1;
  end

  assign acq_addr = base_r + 32'(32'(found_idx_r) * BS_32);

  // bitmap byte access and free read-modify-write
  logic [31:0]       bw_word32;
  logic              bw_ok, cur_bit;
  logic [BIT_W-1:0]  bsh;
  logic [WORD_W-1:0] sh_word, clr_mask;
  logic [7:0]        rd_byte, wr_m;
  logic [9:0]        bit_n;

  always_comb begin
    bw_word32 = 32'(item_r.byte_index) >> 2;
    bw_ok     = (bw_word32 < NW_32);
    bsh       = {item_r.byte_index[1:0], 3'b000};
    sh_word   = rdata_r >> bsh;
    rd_byte   = '0;
    wr_m      = '0;
    bit_n     = '0;
    for (int i = 0; i <= BYTE_MSB; i++) begin
      bit_n = {item_r.byte_index, 3'(i)};
      rd_byte[BYTE_MSB-i] = (BLEN_W'(bit_n) < blen_r) &&
                            ((32'(bit_n) >= NB_32) || !sh_word[i]);
      wr_m[i] = (BLEN_W'(bit_n) < blen_r) && (32'(bit_n) < NB_32) &&
                item_r.byte_value[BYTE_MSB-i];
    end
    clr_mask = WORD_W'(wr_m) << bsh;
    cur_bit  = rdata_r[fidx_r[BIT_W-1:0]];
    if (item_r.action == ACT_FREE) rmw_addr = fidx_r[BIDX_W-1:BIT_W];
    else                           rmw_addr = WA_W'(bw_word32);
  end

  // memory port selection
  always_comb begin
    mem_re    = cmd.scan_rd | cmd.rmw_rd;
    mem_raddr = cmd.scan_rd ? ptr_r[WA_W-1:0] : rmw_addr;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[WA_W-1:0];
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.fill_wr) begin
      mem_we    = 1'b1;
      mem_wdata = fill_word;
    end else if (cmd.hit_wr) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_r;
      mem_wdata = rdata_r & ~low_bit;
    end else if (cmd.rmw_wr) begin
      mem_waddr = rmw_addr;
      if (item_r.action == ACT_FREE) begin
        mem_we    = chk_ok_r & ~cur_bit;
        mem_wdata = rdata_r | (WORD_W'(1) << fidx_r[BIT_W-1:0]);
      end else begin
        mem_we    = (item_r.action == ACT_BM_WR) & bw_ok;
        mem_wdata = rdata_r & ~clr_mask;
      end
    end
  end

  // result register
  fbpa_out_t res_nxt, res_r;

  always_comb begin
    res_nxt = '0;
    case (item_r.action)
      ACT_INIT: res_nxt.ok = 1'b1;
      ACT_ACQUIRE: begin
        res_nxt.ok            = acq_hit_r;
        res_nxt.block_address = acq_hit_r ? acq_addr : 32'd0;
      end
      ACT_FREE:  res_nxt.ok = chk_ok_r & ~cur_bit;
      ACT_BM_WR: res_nxt.ok = 1'b1;
      ACT_BM_RD: begin
        res_nxt.ok          = 1'b1;
        res_nxt.bitmap_byte = rd_byte;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) res_r <= res_nxt;
  end

  assign out_data = res_r;

  // status to the controller
  always_comb begin
    st.act      = item_r.action;
    st.div_done = div_done;
    st.ptr_last = (ptr_r == LAST_PTR);
    st.ptr_over = (ptr_r == OVER_PTR);
    st.hit      = rd_valid_r & (|rdata_r);
    st.miss_end = rd_valid_r & ~(|rdata_r) & (rd_addr_r == LAST_WORD);
    st.chk_ok   = chk_ok_r;
  end

endmodule

### hw/rtl/fbpa_ctrl.sv
// fbpa_ctrl: controller state machine of the allocator
// sequences clearing, init fill, acquire scan, free and bitmap access
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  input  fbpa_pkg::fbpa_stat_t st,
  output fbpa_pkg::fbpa_cmd_t  cmd
);
  import fbpa_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_ADDR   = 4'd6;
  localparam logic [3:0] S_RMW_RD = 4'd7;
  localparam logic [3:0] S_RMW_WR = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0] state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.ptr_clr = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.act)
          ACT_INIT, ACT_FREE: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
          ACT_ACQUIRE: state_nxt = S_SCAN;
          ACT_BM_WR, ACT_BM_RD: begin
            cmd.rmw_rd = 1'b1;
            state_nxt  = S_RMW_WR;
          end
          default: begin
            cmd.res_ld = 1'b1;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.lim_load = 1'b1;
          state_nxt    = (st.act == ACT_INIT) ? S_FILL : S_RMW_RD;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.hit_wr = 1'b1;
          state_nxt  = S_ADDR;
        end else if (st.miss_end) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end else if (!st.ptr_over) begin
          cmd.scan_rd = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_ADDR: begin
        cmd.res_ld = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RMW_RD: begin
        if (st.chk_ok) begin
          cmd.rmw_rd = 1'b1;
          state_nxt  = S_RMW_WR;
        end else begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        cmd.res_ld = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

### hw/rtl/fixed_block_pool_allocator_core.sv
// fixed_block_pool_allocator_core: top level of the fixed block pool allocator
// joins fbpa_ctrl and fbpa_datapath; depends on fbpa_pkg
//
// channel | ports                          | beat taken
// input   | start, busy, in_data           | rising edge with start high and busy low
// result  | out_valid, out_data            | the single cycle out_valid is high
// config  | cfg_we, cfg_index, cfg_data    | rising edge with cfg_we high
//
// one item at a time; the result strobes in the cycle after the work below ends, then busy drops
// init: a 3-step reciprocal divide, then one map word written per cycle
// acquire: scans map words in order to the first free block, or to the last word if none
// free: divide, then one read-modify-write unless rejected; bitmap: one read, and a write for in-range writes
// after reset a clearing pass over every map word holds busy high; config belongs between
// items; the receiver cannot stall results; out_data holds each result for its strobe cycle
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core #(
  parameter int NUM_BLOCKS = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fbpa_pkg::fbpa_in_t              in_data,
  output logic                            out_valid,
  output fbpa_pkg::fbpa_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbpa_pkg::*;

  fbpa_cmd_t  cmd;
  fbpa_stat_t st;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  fbpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

  // an accepted beat keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  // one result per item: the strobe is never high in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // at most one source drives the map write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.fill_wr, cmd.hit_wr, cmd.rmw_wr}))
    else $error("more than one map write in a cycle");

  // a scan hit leads to the acquire result by way of the address state and then the response state
  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit_wr |=> ##1 out_valid)
    else $error("acquire hit did not produce a result");

endmodule
